### hw/rtl/wcmf_pkg.sv
// Shared constants, types and helper functions for the window filter.
package wcmf_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int MaxWindow  = 7;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight);
    localparam int AddrW      = RowW + ColW;
    localparam int MaxTaps    = MaxWindow * MaxWindow;
    localparam int TapW       = $clog2(MaxTaps + 1);
    localparam int SumW       = 8 + TapW;
    localparam int AccW       = 16;

    // configuration register indexes
    localparam logic [1:0] CfgKernel = 2'd0;
    localparam logic [1:0] CfgWindow = 2'd1;
    localparam logic [1:0] CfgWidth  = 2'd2;
    localparam logic [1:0] CfgHeight = 2'd3;

    // kernel_select codes
    localparam logic [3:0] KsAverage  = 4'd0;
    localparam logic [3:0] KsMedian   = 4'd1;
    localparam logic [3:0] KsFirstFix = 4'd2;
    localparam logic [3:0] KsLastFix  = 4'd9;

    // fixed 3x3 kernels, index [mode][row*3+col], 4-bit signed
    typedef logic signed [3:0] t_coef;
    function automatic t_coef kern_coef(input logic [2:0] mode, input logic [3:0] pos);
        t_coef k [8][9];
        k[0] = '{-4'sd1, -4'sd1, -4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd0,  4'sd0,  4'sd0};
        k[1] = '{-4'sd1, -4'sd1, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd1};
        k[2] = '{-4'sd1,  4'sd1,  4'sd0, -4'sd1,  4'sd1,  4'sd0, -4'sd1,  4'sd1,  4'sd0};
        k[3] = '{-4'sd1, -4'sd1, -4'sd1, -4'sd1,  4'sd7, -4'sd1, -4'sd1, -4'sd1, -4'sd1};
        k[4] = '{ 4'sd1,  4'sd1,  4'sd1,  4'sd1, -4'sd8,  4'sd1,  4'sd1,  4'sd1,  4'sd1};
        k[5] = '{-4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1};
        k[6] = '{-4'sd1, -4'sd2, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd2,  4'sd1};
        k[7] = '{-4'sd1,  4'sd0,  4'sd1, -4'sd2,  4'sd0,  4'sd2, -4'sd1,  4'sd0,  4'sd1};
        if (pos < 4'd9) begin
            return k[mode][pos];
        end
        return 4'sd0;
    endfunction

    // centre weight 8 does not fit 4-bit signed; flag it
    function automatic logic kern_is_eight(input logic [2:0] mode, input logic [3:0] pos);
        return (mode == 3'd3) && (pos == 4'd4);
    endfunction

    // mirrored then clamped tap coordinate; limit is 1..256
    function automatic logic [7:0] tap_coord(input logic [7:0] ctr, input logic signed [3:0] off,
                                             input logic [8:0] limit);
        logic signed [10:0] v;
        logic signed [10:0] lim;
        lim = $signed({2'b00, limit});
        v = $signed({3'b000, ctr}) + 11'(off);
        if (v < 0 || v >= lim) begin
            v = $signed({3'b000, ctr}) - 11'(off);
        end
        if (v < 0) begin
            v = '0;
        end
        if (v >= lim) begin
            v = lim - 11'sd1;
        end
        return v[7:0];
    endfunction

    typedef struct packed {
        logic [3:0] ksel;
        logic [2:0] n;
        logic [8:0] w;
        logic [8:0] h;
    } t_cfg;

endpackage

### hw/rtl/window_convolution_median_filter.sv
// Top level: frame store, tap sequencer, shared accumulate/compare unit.
// Load transaction: input is ready again in the next cycle.
// Compute transaction: N*N tap reads, then saturation for fixed kernels (N=3),
// a 14-step divider for average, or rank counting for median;
// input stalls until the result register frees.
// Reset (synchronous, active low) restores control and config registers; the frame store is not cleared.
module window_convolution_median_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_row_index,
    input  logic [7:0] i_col_index,
    input  logic [7:0] i_pixel_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_pixel_out,
    output logic [7:0] o_out_row,
    output logic [7:0] o_out_col,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import wcmf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MED   = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_cfg   r_cfg;

    logic [7:0] mem [MaxWidth*MaxHeight];
    logic [7:0] r_rdata;
    logic [7:0] taps [MaxTaps];

    logic [7:0] r_row, r_col;
    logic [2:0] r_n;
    logic [3:0] r_ksel;
    logic [2:0] r_dr, r_dc;
    logic [TapW-1:0] r_cnt, r_total, r_ia, r_ib, r_wr;
    logic       r_rd_pend;
    logic signed [AccW-1:0] r_acc;
    logic [TapW-1:0] r_less, r_leq;
    logic [7:0] r_va, r_vb;
    logic       r_cmp;
    logic [7:0] r_res;
    logic [7:0] r_out_pix;
    logic [7:0] r_out_row, r_out_col;
    logic       r_out_valid;
    logic [3:0] r_kpos, r_kpos_d;
    logic       fixed_mode;

    logic [2:0] half;
    logic [2:0] n_eff;
    logic [8:0] w_eff, h_eff;
    logic signed [3:0] offr, offc;
    logic [7:0] tr, tc;
    logic [AddrW-1:0] raddr;
    logic            div_start, div_done;
    logic [SumW-1:0] div_q;

    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;

    // frame size clamped to 1..max
    assign w_eff = (r_cfg.w == 9'd0) ? 9'd1 :
                   (r_cfg.w > 9'(MaxWidth)) ? 9'(MaxWidth) : r_cfg.w;
    assign h_eff = (r_cfg.h == 9'd0) ? 9'd1 :
                   (r_cfg.h > 9'(MaxHeight)) ? 9'(MaxHeight) : r_cfg.h;

    assign fixed_mode = (r_ksel >= KsFirstFix) && (r_ksel <= KsLastFix);
    assign half = r_n >> 1;
    assign offr = $signed({1'b0, r_dr}) - $signed({1'b0, half});
    assign offc = $signed({1'b0, r_dc}) - $signed({1'b0, half});
    assign tr = tap_coord(r_row, offr, h_eff);
    assign tc = tap_coord(r_col, offc, w_eff);
    assign raddr = {tr, tc};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ksel: KsAverage, n: 3'd3, w: 9'd256, h: 9'd256};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CfgKernel: r_cfg.ksel <= i_cfg_data[3:0];
                CfgWindow: r_cfg.n    <= i_cfg_data[2:0];
                CfgWidth:  r_cfg.w    <= i_cfg_data;
                CfgHeight: r_cfg.h    <= i_cfg_data;
                default:   r_cfg      <= r_cfg;
            endcase
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_cmd) begin
            mem[{i_row_index, i_col_index}] <= i_pixel_in;
        end
        r_rdata <= mem[raddr];
    end

    wcmf_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc[SumW-1:0]),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quot     (div_q)
    );
    assign div_start = (r_state == S_DRAIN) && !r_rd_pend && (r_ksel == KsAverage);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && i_cmd) n_state = S_READ;
            S_READ:  if (r_cnt == r_total - 1'b1) n_state = S_DRAIN;
            S_DRAIN: begin
                if (!r_rd_pend) begin
                    if (r_ksel == KsAverage)     n_state = S_DIV;
                    else if (r_ksel == KsMedian) n_state = S_MED;
                    else                         n_state = S_SAT;
                end
            end
            S_DIV:   if (div_done) n_state = S_OUT;
            S_MED:   if (r_ia == r_total) n_state = S_OUT;
            S_SAT:   n_state = S_OUT;
            S_OUT:   if (!r_out_valid || out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign n_eff = (r_cfg.n == 3'd0) ? 3'd1 : r_cfg.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_out_valid || out_acc)) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            // read pipeline: data returns in the cycle after its address
            r_rd_pend <= (r_state == S_READ);
        end

        unique case (r_state)
            S_IDLE: begin
                r_row  <= i_row_index;
                r_col  <= i_col_index;
                r_ksel <= r_cfg.ksel;
                if (r_cfg.ksel >= KsFirstFix) begin
                    r_n <= 3'd3;
                end else begin
                    r_n <= n_eff;
                end
                r_total <= (r_cfg.ksel >= KsFirstFix) ? TapW'(9) :
                           TapW'(n_eff) * TapW'(n_eff);
                r_dr <= '0;
                r_dc <= '0;
                r_cnt <= '0;
                r_wr <= '0;
                r_kpos <= '0;
                r_acc <= '0;
                r_ia <= '0;
                r_ib <= '0;
                r_less <= '0;
                r_leq <= '0;
                r_cmp <= 1'b0;
            end
            S_READ: begin
                r_cnt <= r_cnt + 1'b1;
                r_kpos <= r_kpos + 1'b1;
                if (r_dc == r_n - 1'b1) begin
                    r_dc <= '0;
                    r_dr <= r_dr + 1'b1;
                end else begin
                    r_dc <= r_dc + 1'b1;
                end
            end
            default: ;
        endcase
        r_kpos_d <= r_kpos;

        // shared accumulate unit consumes returned tap data
        if (r_rd_pend) begin
            taps[r_wr] <= r_rdata;
            r_wr <= r_wr + 1'b1;
            if (fixed_mode) begin
                if (kern_is_eight(3'(r_ksel - KsFirstFix), r_kpos_d)) begin
                    r_acc <= r_acc + AccW'(signed'({1'b0, r_rdata, 3'b000}));
                end else begin
                    r_acc <= r_acc + AccW'(kern_coef(3'(r_ksel - KsFirstFix), r_kpos_d))
                                   * AccW'(signed'({1'b0, r_rdata}));
                end
            end else begin
                r_acc <= r_acc + AccW'(signed'({1'b0, r_rdata}));
            end
        end

        // tap buffer reads for the median, registered
        if (r_state == S_MED) begin
            r_va <= taps[r_ia];
            r_vb <= taps[r_ib];
        end

        // median by rank counting: one compare per cycle, in the cycle after its read
        if (r_state == S_MED && r_ia != r_total) begin
            r_cmp <= (r_ib < r_total);
            if (r_cmp) begin
                if (r_vb < r_va) r_less <= r_less + 1'b1;
                if (r_vb <= r_va) r_leq <= r_leq + 1'b1;
            end
            if (r_ib == r_total + 1'b1) begin
                if ((r_less <= (r_total >> 1)) && ((r_total >> 1) < r_leq)) begin
                    r_res <= r_va;
                end
                r_ia <= r_ia + 1'b1;
                r_ib <= '0;
                r_less <= '0;
                r_leq <= '0;
            end else begin
                r_ib <= r_ib + 1'b1;
            end
        end

        if (r_state == S_DIV && div_done) begin
            r_res <= div_q[7:0];
        end
        if (r_state == S_SAT) begin
            if (!fixed_mode || r_acc < 0) begin
                r_res <= '0;
            end else if (r_acc > 255) begin
                r_res <= 8'hFF;
            end else begin
                r_res <= r_acc[7:0];
            end
        end
        // result register, held while stalled
        if (r_state == S_OUT && (!r_out_valid || out_acc)) begin
            r_out_pix <= r_res;
            r_out_row <= r_row;
            r_out_col <= r_col;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
endmodule

### hw/rtl/wcmf_divider.sv
// Restoring serial divider: one quotient bit per cycle.
module wcmf_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wcmf_pkg::SumW-1:0] i_dividend,
    input  logic [wcmf_pkg::TapW-1:0] i_divisor,
    output logic                      o_done,
    output logic [wcmf_pkg::SumW-1:0] o_quot
);
    import wcmf_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0] r_quot, n_quot;
    logic [TapW:0]   r_rem, n_rem;
    logic [TapW-1:0] r_dsr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy, r_done, n_done;
    logic [TapW:0]   trial;

    // one shift-subtract step
    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem[TapW-1:0], r_quot[SumW-1]};
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = CntW'(SumW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = trial - {1'b0, r_dsr};
                n_quot = {r_quot[SumW-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quot = {r_quot[SumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### hw/rtl/wcmf_checker.sv
// Port-level checker for the window filter, bound to the top level.
module wcmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_cmd,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_pixel_out,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out))
        else $error("result dropped or changed under stall");
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_cmd |=> !o_stall)
        else $error("load transaction did not return to ready");
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_cmd |=> o_stall)
        else $error("compute transaction did not hold the input");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_stall && !o_valid)
        else $error("config ready while busy");
endmodule

bind window_convolution_median_filter wcmf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_cmd(i_cmd), .o_valid(o_valid), .i_stall(i_stall), .o_pixel_out(o_pixel_out),
    .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready)
);

### bench/tb_top.sv
// Self-checking testbench for the window filter: directed table, then random phases.
module tb_top;
    import wcmf_pkg::*;

    typedef struct {
        logic [7:0] pix;
        logic [7:0] row;
        logic [7:0] col;
    } t_filt_result;

    typedef struct {
        logic       cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] pix;
        logic       known;
        logic [7:0] exp_pix;
    } t_dir_row;

    localparam logic CmdLoad    = 1'b0;
    localparam logic CmdCompute = 1'b1;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_cmd;
    logic [7:0] i_row_index;
    logic [7:0] i_col_index;
    logic [7:0] i_pixel_in;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_pixel_out;
    logic [7:0] o_out_row;
    logic [7:0] o_out_col;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    window_convolution_median_filter dut (.*);

    // predictor state
    logic [7:0]   frame_mem [MaxWidth*MaxHeight];
    bit           frame_written [MaxWidth*MaxHeight];
    t_cfg         cur_cfg;
    t_filt_result filtered_q [$];
    int           errors;
    int           items_sent;
    bit           quiet;
    int           coef [8][9] = '{
        '{-1, -1, -1,  1,  1,  1,  0,  0,  0},
        '{-1, -1, -1,  0,  0,  0,  1,  1,  1},
        '{-1,  1,  0, -1,  1,  0, -1,  1,  0},
        '{-1, -1, -1, -1,  8, -1, -1, -1, -1},
        '{ 1,  1,  1,  1, -8,  1,  1,  1,  1},
        '{-1,  0,  1, -1,  0,  1, -1,  0,  1},
        '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
        '{-1,  0,  1, -2,  0,  2, -1,  0,  1}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(240_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int eff_n();
        if (cur_cfg.n == 0) return 1;
        return (cur_cfg.n > MaxWindow) ? MaxWindow : int'(cur_cfg.n);
    endfunction

    function automatic int eff_dim(input logic [8:0] v, input int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : int'(v);
    endfunction

    // mirror about the centre, then clamp to the edge
    function automatic int mirror_clamp(input int ctr, input int off, input int lim);
        int v;
        v = ctr + off;
        if (v < 0 || v >= lim) v = ctr - off;
        if (v < 0) v = 0;
        if (v >= lim) v = lim - 1;
        return v;
    endfunction

    function automatic int tap_addr(input int r, input int c, input int dr, input int dc);
        int w;
        int h;
        w = eff_dim(cur_cfg.w, MaxWidth);
        h = eff_dim(cur_cfg.h, MaxHeight);
        return mirror_clamp(r, dr, h) * MaxWidth + mirror_clamp(c, dc, w);
    endfunction

    // true when every tap the filter could read has been loaded
    function automatic bit window_loaded(input int r, input int c);
        int n;
        n = eff_n();
        for (int dr = 0; dr < n; dr++)
            for (int dc = 0; dc < n; dc++)
                if (!frame_written[tap_addr(r, c, dr - n/2, dc - n/2)]) return 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (!frame_written[tap_addr(r, c, dr, dc)]) return 0;
        return 1;
    endfunction

    function automatic logic [7:0] filtered_pixel(input int r, input int c);
        int n;
        int acc;
        int cnt;
        int j;
        logic [7:0] vals [MaxTaps];
        logic [7:0] t;
        n = eff_n();
        acc = 0;
        cnt = 0;
        if (cur_cfg.ksel == KsAverage || cur_cfg.ksel == KsMedian) begin
            for (int dr = 0; dr < n; dr++)
                for (int dc = 0; dc < n; dc++) begin
                    vals[cnt] = frame_mem[tap_addr(r, c, dr - n/2, dc - n/2)];
                    acc += vals[cnt];
                    cnt++;
                end
            if (cur_cfg.ksel == KsAverage) begin
                acc = acc / (n * n);
            end else begin
                for (int a = 1; a < cnt; a++) begin
                    t = vals[a];
                    j = a;
                    while (j > 0 && vals[j-1] > t) begin
                        vals[j] = vals[j-1];
                        j--;
                    end
                    vals[j] = t;
                end
                acc = vals[cnt/2];
            end
        end else if (cur_cfg.ksel <= KsLastFix) begin
            for (int dr = 0; dr < 3; dr++)
                for (int dc = 0; dc < 3; dc++)
                    acc += coef[cur_cfg.ksel - KsFirstFix][dr*3 + dc] *
                           int'(frame_mem[tap_addr(r, c, dr - 1, dc - 1)]);
        end
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return acc[7:0];
    endfunction

    // drive one input transaction and wait until it is taken
    task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] c,
                             input logic [7:0] p);
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_row_index <= r;
        i_col_index <= c;
        i_pixel_in  <= p;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (!quiet && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic load_pixel(input logic [7:0] r, input logic [7:0] c, input logic [7:0] p);
        frame_mem[{r, c}]     = p;
        frame_written[{r, c}] = 1'b1;
        send_item(CmdLoad, r, c, p);
    endtask

    task automatic compute_pixel(input logic [7:0] r, input logic [7:0] c, input logic [7:0] p);
        filtered_q.push_back('{filtered_pixel(r, c), r, c});
        send_item(CmdCompute, r, c, p);
    endtask

    // register write, only with nothing in flight
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        i_valid <= 1'b0;
        wait (filtered_q.size() == 0);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CfgKernel: cur_cfg.ksel = data[3:0];
            CfgWindow: cur_cfg.n    = data[2:0];
            CfgWidth:  cur_cfg.w    = data;
            CfgHeight: cur_cfg.h    = data;
        endcase
    endtask

    function automatic logic [7:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return 8'($urandom_range(11));
        if (sel < 90) return 8'($urandom_range(244, 255));
        return 8'($urandom_range(255));
    endfunction

    // result side: random stall, compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_filt_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_q.size() == 0) begin
                $error("unexpected result row=%0d col=%0d pix=%0d",
                       o_out_row, o_out_col, o_pixel_out);
                errors++;
            end else begin
                e = filtered_q.pop_front();
                if (o_pixel_out !== e.pix) begin
                    $error("pixel_out expected %0d actual %0d", e.pix, o_pixel_out);
                    errors++;
                end
                if (o_out_row !== e.row) begin
                    $error("out_row expected %0d actual %0d", e.row, o_out_row);
                    errors++;
                end
                if (o_out_col !== e.col) begin
                    $error("out_col expected %0d actual %0d", e.col, o_out_col);
                    errors++;
                end
            end
        end
        i_stall <= !quiet && ($urandom_range(99) < 10);
    end

    // stimulus
    initial begin
        t_dir_row    dir_tab [$];
        int          tries;
        logic [7:0]  r;
        logic [7:0]  c;
        logic [8:0]  dims [10];

        dims = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd16, 9'd256, 9'd300, 9'd511};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = 1'b0;
        i_row_index = '0;
        i_col_index = '0;
        i_pixel_in  = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        errors      = 0;
        items_sent  = 0;
        quiet       = 1'b0;
        cur_cfg     = '{ksel: KsAverage, n: 3'd3, w: 9'd256, h: 9'd256};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners at full scale, reset settings (3x3 average, 256x256)
        dir_tab = '{
            '{CmdLoad,    8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
            '{CmdLoad,    8'd0,   8'd1,   8'd255, 1'b0, 8'd0},
            '{CmdLoad,    8'd1,   8'd0,   8'd255, 1'b0, 8'd0},
            '{CmdLoad,    8'd1,   8'd1,   8'd255, 1'b0, 8'd0},
            '{CmdCompute, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
            '{CmdLoad,    8'd255, 8'd255, 8'd0,   1'b0, 8'd0},
            '{CmdLoad,    8'd254, 8'd255, 8'd0,   1'b0, 8'd0},
            '{CmdLoad,    8'd255, 8'd254, 8'd0,   1'b0, 8'd0},
            '{CmdLoad,    8'd254, 8'd254, 8'd0,   1'b0, 8'd0},
            '{CmdCompute, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
            '{CmdLoad,    8'd2,   8'd0,   8'd17,  1'b0, 8'd0},
            '{CmdLoad,    8'd2,   8'd1,   8'd90,  1'b0, 8'd0},
            '{CmdLoad,    8'd2,   8'd2,   8'd3,   1'b0, 8'd0},
            '{CmdLoad,    8'd0,   8'd2,   8'd128, 1'b0, 8'd0},
            '{CmdLoad,    8'd1,   8'd2,   8'd1,   1'b0, 8'd0},
            '{CmdCompute, 8'd1,   8'd1,   8'd0,   1'b0, 8'd0},
            '{CmdCompute, 8'd0,   8'd1,   8'd0,   1'b0, 8'd0}
        };
        foreach (dir_tab[k]) begin
            if (dir_tab[k].cmd == CmdLoad) begin
                load_pixel(dir_tab[k].row, dir_tab[k].col, dir_tab[k].pix);
            end else if (dir_tab[k].known) begin
                filtered_q.push_back('{dir_tab[k].exp_pix, dir_tab[k].row, dir_tab[k].col});
                send_item(CmdCompute, dir_tab[k].row, dir_tab[k].col, dir_tab[k].pix);
            end else begin
                compute_pixel(dir_tab[k].row, dir_tab[k].col, dir_tab[k].pix);
            end
        end

        // random phases: every kernel code, window and frame sizes incl. out-of-range
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(CfgKernel, {5'($urandom_range(31)), 4'(ph)});
            if (ph == 0 || ph == 1)
                write_reg(CfgWindow, {6'($urandom_range(63)), 3'd7});
            else
                write_reg(CfgWindow, 9'($urandom_range(511)));
            write_reg(CfgWidth,  (ph == 0) ? 9'd256 : dims[$urandom_range(9)]);
            write_reg(CfgHeight, (ph == 0) ? 9'd256 : dims[$urandom_range(9)]);
            for (int k = 0; k < 68; k++) begin
                quiet = (items_sent > 350 && items_sent < 500);
                r = pick_coord();
                c = pick_coord();
                if ($urandom_range(99) < 45) begin
                    load_pixel(r, c, 8'($urandom_range(255)));
                end else begin
                    tries = 0;
                    while (!window_loaded(r, c) && tries < 8) begin
                        r = pick_coord();
                        c = pick_coord();
                        tries++;
                    end
                    if (window_loaded(r, c))
                        compute_pixel(r, c, 8'($urandom_range(255)));
                    else
                        load_pixel(r, c, 8'($urandom_range(255)));
                end
            end
        end

        // drain
        i_valid <= 1'b0;
        quiet = 1'b0;
        wait (filtered_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && filtered_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
